[rtl/afvt_pkg.sv]
package afvt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int SQ_ITERS      = 32;
  localparam int SQ_PER_STAGE  = 2;
  localparam int SQ_STAGES     = SQ_ITERS / SQ_PER_STAGE;

  localparam logic [63:0] REG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'h0001_0000_0000_0000, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'h0001_0000_0000_0000
  };

  // matrix entries, [row][col]
  typedef logic [3:0][3:0][31:0] mat_t;

  typedef struct packed {
    logic               hit;
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] cz;
    logic signed [63:0] w;
  } side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  // one digit of the restoring square root
  function automatic sq_t sqrt_step(input sq_t cur, input logic [63:0] bitv);
    sq_t nxt;
    if (cur.rem >= cur.root + bitv) begin
      nxt.rem  = cur.rem - (cur.root + bitv);
      nxt.root = (cur.root >> 1) + bitv;
    end else begin
      nxt.rem  = cur.rem;
      nxt.root = cur.root >> 1;
    end
    return nxt;
  endfunction

endpackage

[rtl/afvt_xform.sv]
module afvt_xform import afvt_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  mat_t          mat,
  input  logic          in_valid,
  input  logic [191:0]  in_data,
  output logic          out_valid,
  output side_t         out_side,
  output logic [63:0]   out_sumsq
);

  logic               v1, v2, v3;
  logic signed [31:0] lo1 [3];
  logic signed [31:0] hi1 [3];
  logic signed [31:0] ctr1 [3];
  logic signed [31:0] ext1 [3];
  logic signed [31:0] lo_in [3];
  logic signed [31:0] hi_in [3];
  logic signed [32:0] sum_in [3];
  logic signed [32:0] dif_in [3];

  logic signed [63:0] pc [4][3][2];
  logic signed [63:0] pm [4][3];
  logic [63:0]        sq2 [3];

  logic signed [63:0] cc [8][4];
  logic signed [63:0] cm [4];
  logic [63:0]        sumsq3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_in[i]  = in_data[32*i +: 32];
      hi_in[i]  = in_data[32*(i+3) +: 32];
      sum_in[i] = 33'(lo_in[i]) + 33'(hi_in[i]);
      dif_in[i] = 33'(hi_in[i]) - 33'(lo_in[i]);
    end
  end

  // stage 1: centre and half extents
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        lo1[i]  <= lo_in[i];
        hi1[i]  <= hi_in[i];
        ctr1[i] <= 32'(sum_in[i] >>> 1);
        ext1[i] <= 32'(dif_in[i] >>> 1);
      end
    end
  end

  // stage 2: scaled products for both corner choices and the centre, and squared half extents
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          pc[r][c][0] <= (64'(signed'(mat[r][c])) * 64'(lo1[c])) >>> FracBits;
          pc[r][c][1] <= (64'(signed'(mat[r][c])) * 64'(hi1[c])) >>> FracBits;
          pm[r][c]    <= (64'(signed'(mat[r][c])) * 64'(ctr1[c])) >>> FracBits;
        end
      end
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= 64'(64'(ext1[i]) * 64'(ext1[i]));
      end
    end
  end

  // stage 3: clip coordinates of eight corners and the centre, and the sum of squares
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 8; k++) begin
        for (int r = 0; r < 4; r++) begin
          cc[k][r] <= 64'(signed'(mat[r][3])) + pc[r][0][k[0]]
                    + pc[r][1][k[1]] + pc[r][2][k[2]];
        end
      end
      for (int r = 0; r < 4; r++) begin
        cm[r] <= 64'(signed'(mat[r][3])) + pm[r][0] + pm[r][1] + pm[r][2];
      end
      sumsq3 <= sq2[0] + sq2[1] + sq2[2];
    end
  end

  // stage 4: inside test for every corner
  logic hit_c;
  always_comb begin
    hit_c = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (cc[k][3] > 0 &&
          cc[k][0] <= cc[k][3] && -cc[k][0] <= cc[k][3] &&
          cc[k][1] <= cc[k][3] && -cc[k][1] <= cc[k][3] &&
          cc[k][2] <= cc[k][3] && -cc[k][2] <= cc[k][3]) begin
        hit_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_side.hit <= hit_c;
      out_side.cx  <= cm[0];
      out_side.cy  <= cm[1];
      out_side.cz  <= cm[2];
      out_side.w   <= cm[3];
      out_sumsq    <= sumsq3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

endmodule

[rtl/afvt_sqrt.sv]
module afvt_sqrt import afvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        ce,
  input  logic        in_valid,
  input  logic [63:0] in_sumsq,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] out_root,
  output side_t       out_side
);

  logic  v    [SQ_STAGES+1];
  sq_t   st   [SQ_STAGES+1];
  side_t sd   [SQ_STAGES+1];

  assign v[0]        = in_valid;
  assign st[0].rem   = in_sumsq;
  assign st[0].root  = '0;
  assign sd[0]       = in_side;

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    sq_t step_q [SQ_PER_STAGE+1];
    always_comb begin
      step_q[0] = st[g];
      for (int j = 0; j < SQ_PER_STAGE; j++) begin
        step_q[j+1] = sqrt_step(step_q[j],
                                64'(1) << (62 - 2 * (g * SQ_PER_STAGE + j)));
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st[g+1] <= step_q[SQ_PER_STAGE];
        sd[g+1] <= sd[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (ce) begin
        v[g+1] <= v[g];
      end
    end
  end

  assign out_valid = v[SQ_STAGES];
  assign out_root  = st[SQ_STAGES].root[31:0];
  assign out_side  = sd[SQ_STAGES];

endmodule

[rtl/afvt_bound.sv]
module afvt_bound import afvt_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ce,
  input  logic        in_valid,
  input  logic [31:0] in_root,
  input  side_t       in_side,
  output logic        out_valid,
  output logic        out_visible,
  output logic        out_hit
);

  logic        v1, v2;
  logic        hit1, hit2, wpos1, wpos2;
  logic [64:0] plo1, phi1;
  logic [63:0] mag1 [3];
  logic [63:0] mag2 [3];
  logic [97:0] prod2;
  logic [32:0] kf;
  logic        ok;

  assign kf = (33'(1) << FracBits) + 33'(in_root);

  // stage 1: w * (1 + r) as two partial products
  always_ff @(posedge clk) begin
    if (ce) begin
      hit1  <= in_side.hit;
      wpos1 <= in_side.w > 0;
      plo1  <= 65'(in_side.w[31:0]) * 65'(kf);
      phi1  <= 65'(in_side.w[63:32]) * 65'(kf);
      mag1[0] <= in_side.cx[63] ? 64'(-in_side.cx) : 64'(in_side.cx);
      mag1[1] <= in_side.cy[63] ? 64'(-in_side.cy) : 64'(in_side.cy);
      mag1[2] <= in_side.cz[63] ? 64'(-in_side.cz) : 64'(in_side.cz);
    end
  end

  // stage 2: combine partials
  always_ff @(posedge clk) begin
    if (ce) begin
      hit2  <= hit1;
      wpos2 <= wpos1;
      prod2 <= (98'(phi1) << 32) + 98'(plo1);
      for (int i = 0; i < 3; i++) begin
        mag2[i] <= mag1[i];
      end
    end
  end

  always_comb begin
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ((128'(mag2[i]) << FracBits) > 128'(prod2)) begin
        ok = 1'b0;
      end
    end
  end

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (ce) begin
      out_hit     <= hit2;
      out_visible <= hit2 | (wpos2 & ok);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

endmodule

[rtl/aabb_frustum_visibility_test_top.sv]
// Box-against-frustum culling: each request carries an axis-aligned box, and
// the block answers visible/corner_hit using the 4x4 view-projection matrix
// held in eight 64-bit configuration registers (identity after reset). The
// datapath is fully pipelined and accepts one box every clock unless the output
// stalls it; a result passes through 4 transform stages, 16 stages of the radius
// square root at two digits each and 3 bound stages. The whole pipeline
// holds while the result register is full and not taken. Configuration writes
// are accepted whenever reset is low and must only be made while no box is in
// flight.
module aabb_frustum_visibility_test_top import afvt_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [191:0]         s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // visible, corner_hit, zero pad
  output logic [7:0]           m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0] regs [NUM_REGS];
  mat_t        mat;
  logic        ce;

  logic        xf_valid;
  side_t       xf_side;
  logic [63:0] xf_sumsq;
  logic        sq_valid;
  logic [31:0] sq_root;
  side_t       sq_side;
  logic        vis, hit;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= REG_RESET[i];
      end
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = regs[r * 2 + c / 2][(c % 2) * 32 +: 32];
      end
    end
  end

  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce && !rst;

  afvt_xform #(.FracBits(FracBits)) u_xform (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .mat       (mat),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (xf_valid),
    .out_side  (xf_side),
    .out_sumsq (xf_sumsq)
  );

  afvt_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (xf_valid),
    .in_sumsq  (xf_sumsq),
    .in_side   (xf_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  afvt_bound #(.FracBits(FracBits)) u_bound (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .in_valid    (sq_valid),
    .in_root     (sq_root),
    .in_side     (sq_side),
    .out_valid   (m_axis_tvalid),
    .out_visible (vis),
    .out_hit     (hit)
  );

  assign m_axis_tdata = {6'b0, hit, vis};

  // a corner inside always means visible
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("corner hit without visible");

  // nothing comes out straight after reset
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // a held result leaves the pipeline frozen
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(sq_valid) && $stable(xf_valid))
    else $error("pipeline moved during stall");

endmodule
